FILE: rtl/nacu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nacu_pkg
// Types and constants shared by the neighbor advertisement cache update unit.
// ----------------------------------------------------------------------------
package nacu_pkg;

   localparam logic [15:0] ETHERTYPE_V6      = 16'h86DD;
   localparam logic [7:0]  ICMP_NEIGH_ADVERT = 8'd136;
   localparam logic [7:0]  OPT_TARGET_LL     = 8'd2;
   localparam logic [31:0] AGE_RESET         = 32'd120;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int SLOT_W     = 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OWN_MAC      = 3'd0,
      CSR_GLOBAL_IP_HI = 3'd1,
      CSR_GLOBAL_IP_LO = 3'd2,
      CSR_LINK_IP_HI   = 3'd3,
      CSR_LINK_IP_LO   = 3'd4,
      CSR_QUERY_IP_HI  = 3'd5,
      CSR_QUERY_IP_LO  = 3'd6,
      CSR_AGE_LIMIT    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_REJECT = 2'd0,
      STATUS_HIT    = 2'd1,
      STATUS_FILL   = 2'd2,
      STATUS_EVICT  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [15:0] ether_type;
      logic [47:0] dst_mac;
      logic [63:0] ip_dst_hi;
      logic [63:0] ip_dst_lo;
      logic [63:0] ip_src_hi;
      logic [63:0] ip_src_lo;
      logic [7:0]  icmp_type;
      logic [63:0] target_hi;
      logic [63:0] target_lo;
      logic [7:0]  option_type;
      logic [47:0] option_mac;
      logic [31:0] now_tick;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic [63:0] ip_hi;
      logic [63:0] ip_lo;
      logic [47:0] mac;
      logic [31:0] stamp;
   } entry_type;

endpackage

FILE: rtl/nacu_entry_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nacu_entry_store
// Neighbor cache memory: one write port, one registered read port. Per-entry
// valid bits make never-written entries read as all zero after reset.
// ----------------------------------------------------------------------------
module nacu_entry_store
   import nacu_pkg::*;
#(
   parameter int CACHE_ENTRIES = 8,
   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_entry,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_entry
);

   entry_type                entry_mem_ff [CACHE_ENTRIES];
   entry_type                rd_q_ff;
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_q_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_q_ff : '0;

endmodule

FILE: rtl/neighbor_advert_cache_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_advert_cache_update_unit
// Validates a received IPv6 neighbor advertisement and records the sender in
// a small neighbor cache, reporting the slot used.
//
//   channel  ports                          direction  transfer when
//   req      req_valid/req_ready/req_data   in         valid & ready
//   rsp      rsp_valid/rsp_ready/rsp_data   out        valid & ready
//   csr      csr_we/csr_addr/csr_wdata      in         csr_we
//
// A rejected item visits no cache entry, an accepted one 1..CACHE_ENTRIES. The
// scan reads one entry a cycle from the single memory read port and runs it
// through one age subtract/compare unit.
// Reset clears control and the cache valid bits and sets configuration to defaults.
// req_ready is high only while idle; a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module neighbor_advert_cache_update_unit
   import nacu_pkg::*;
#(
   parameter int CACHE_ENTRIES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

   logic [47:0] own_mac_ff;
   logic [63:0] global_ip_hi_ff, global_ip_lo_ff;
   logic [63:0] link_ip_hi_ff, link_ip_lo_ff;
   logic [63:0] query_ip_hi_ff, query_ip_lo_ff;
   logic [31:0] age_limit_ff;

   req_type           req_ff;
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   status_type        res_status_ff, res_status_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic             chk_ok;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_entry;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [31:0]      age;
   logic             ent_hit;
   logic             ent_take;
   logic             req_xfer;
   logic             emit_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff      <= '0;
         global_ip_hi_ff <= '0;
         global_ip_lo_ff <= '0;
         link_ip_hi_ff   <= '0;
         link_ip_lo_ff   <= '0;
         query_ip_hi_ff  <= '0;
         query_ip_lo_ff  <= '0;
         age_limit_ff    <= AGE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_OWN_MAC:      own_mac_ff      <= csr_wdata[47:0];
            CSR_GLOBAL_IP_HI: global_ip_hi_ff <= csr_wdata;
            CSR_GLOBAL_IP_LO: global_ip_lo_ff <= csr_wdata;
            CSR_LINK_IP_HI:   link_ip_hi_ff   <= csr_wdata;
            CSR_LINK_IP_LO:   link_ip_lo_ff   <= csr_wdata;
            CSR_QUERY_IP_HI:  query_ip_hi_ff  <= csr_wdata;
            CSR_QUERY_IP_LO:  query_ip_lo_ff  <= csr_wdata;
            CSR_AGE_LIMIT:    age_limit_ff    <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign emit_go   = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp_ready);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_data;
      end
   end

   assign chk_ok = (req_ff.ether_type == ETHERTYPE_V6)
                 & (req_ff.dst_mac == own_mac_ff)
                 & (((req_ff.ip_dst_hi == global_ip_hi_ff) &
                     (req_ff.ip_dst_lo == global_ip_lo_ff)) |
                    ((req_ff.ip_dst_hi == link_ip_hi_ff) &
                     (req_ff.ip_dst_lo == link_ip_lo_ff)))
                 & (req_ff.ip_src_hi == query_ip_hi_ff)
                 & (req_ff.ip_src_lo == query_ip_lo_ff)
                 & (req_ff.icmp_type == ICMP_NEIGH_ADVERT)
                 & (req_ff.target_hi == query_ip_hi_ff)
                 & (req_ff.target_lo == query_ip_lo_ff)
                 & (req_ff.option_type == OPT_TARGET_LL);

   assign age      = req_ff.now_tick - rd_entry.stamp;
   assign ent_hit  = (rd_entry.ip_hi == req_ff.ip_src_hi) &
                     (rd_entry.ip_lo == req_ff.ip_src_lo) &
                     (age <= age_limit_ff);
   assign ent_take = (rd_entry.stamp == '0) | (age > age_limit_ff);

   assign wr_entry.ip_hi = req_ff.ip_src_hi;
   assign wr_entry.ip_lo = req_ff.ip_src_lo;
   assign wr_entry.mac   = req_ff.option_mac;
   assign wr_entry.stamp = req_ff.now_tick;

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = scan_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            scan_idx_in = '0;
            res_slot_in = '0;
            if (chk_ok) begin
               rd_en    = 1'b1;
               state_in = ST_SCAN;
            end else begin
               res_status_in = STATUS_REJECT;
               state_in      = ST_EMIT;
            end
         end
         ST_SCAN: begin
            res_slot_in = SLOT_W'(scan_idx_ff);
            if (ent_hit) begin
               res_status_in = STATUS_HIT;
               state_in      = ST_EMIT;
            end else if (ent_take) begin
               wr_en         = 1'b1;
               res_status_in = STATUS_FILL;
               state_in      = ST_EMIT;
            end else if (scan_idx_ff == LAST_IDX) begin
               wr_en         = 1'b1;
               wr_addr       = '0;
               res_status_in = STATUS_EVICT;
               res_slot_in   = '0;
               state_in      = ST_EMIT;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = scan_idx_ff + IDX_W'(1);
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      if (emit_go) begin
         rsp_ff.status <= res_status_ff;
         rsp_ff.slot   <= res_slot_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   nacu_entry_store #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

endmodule
